// ===== hw/rtl/blh_pkg.sv =====
// shared types and constants for the burst length histogram
`default_nettype none

package blh_pkg;

    localparam int TIME_W = 32;
    localparam int CODE_W = 8;
    localparam int LEN_W  = 16;
    localparam int CNT_W  = 32;
    localparam int IDX_W  = 8;
    localparam int DATA_W = 32;

    localparam logic [IDX_W-1:0] REG_GAP_THRESHOLD = 8'd0;
    localparam logic [IDX_W-1:0] REG_SPIKE_MARKER  = 8'd1;

    localparam logic [TIME_W-1:0] GAP_THRESHOLD_RESET = 32'd50;
    localparam logic [CODE_W-1:0] SPIKE_MARKER_RESET  = 8'd20;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] length;
        logic [LEN_W-1:0] longest;
        logic             clip;
    } burst_t;

endpackage

`default_nettype wire

// ===== hw/rtl/blh_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module blh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/blh_front.sv =====
// input register and run tracking: gap test, run length, longest run, bin select
`default_nettype none

module blh_front
    import blh_pkg::*;
#(
    parameter int HIST_BINS = 32,
    localparam int BIN_W = $clog2(HIST_BINS)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              take,
    input  wire logic [TIME_W-1:0] sample_time,
    input  wire logic [CODE_W-1:0] event_code,
    input  wire logic [TIME_W-1:0] gap_threshold,
    input  wire logic [CODE_W-1:0] spike_marker,
    output burst_t                 burst,
    output logic      [BIN_W-1:0]  bin
);

    logic              s1_valid_reg, s1_valid_next;
    logic [TIME_W-1:0] s1_time_reg;
    logic [CODE_W-1:0] s1_code_reg;
    logic [TIME_W-1:0] last_time_reg, last_time_next;
    logic              seen_reg, seen_next;
    logic [LEN_W-1:0]  run_reg, run_next;
    logic [LEN_W-1:0]  longest_reg, longest_next;

    logic [TIME_W-1:0] ref_time;
    logic [TIME_W-1:0] gap;
    logic              spike;
    logic              close;
    logic              clip;
    logic [LEN_W-1:0]  longest_new;

    always_comb
    begin
        ref_time    = seen_reg ? last_time_reg : s1_time_reg;
        gap         = (s1_time_reg >= ref_time) ? (s1_time_reg - ref_time)
                                                : (ref_time - s1_time_reg);
        spike       = s1_valid_reg && (s1_code_reg == spike_marker);
        close       = spike && !(gap < gap_threshold);
        clip        = run_reg > LEN_W'(HIST_BINS - 1);
        bin         = clip ? BIN_W'(HIST_BINS - 1) : run_reg[BIN_W-1:0];
        longest_new = (run_reg > longest_reg) ? run_reg : longest_reg;
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        last_time_next = last_time_reg;
        seen_next      = seen_reg;
        run_next       = run_reg;
        longest_next   = longest_reg;
        if (advance)
        begin
            s1_valid_next = take;
            if (s1_valid_reg)
            begin
                if (!seen_reg)
                begin
                    seen_next      = 1'b1;
                    last_time_next = s1_time_reg;
                end
                if (spike)
                begin
                    last_time_next = s1_time_reg;
                    if (close)
                    begin
                        run_next     = LEN_W'(1);
                        longest_next = longest_new;
                    end
                    else if (run_reg != LEN_MAX)
                    begin
                        run_next = run_reg + LEN_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            last_time_reg <= '0;
            seen_reg      <= 1'b0;
            run_reg       <= LEN_W'(1);
            longest_reg   <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            last_time_reg <= last_time_next;
            seen_reg      <= seen_next;
            run_reg       <= run_next;
            longest_reg   <= longest_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && take)
        begin
            s1_time_reg <= sample_time;
            s1_code_reg <= event_code;
        end
    end

    assign burst = '{valid: close, length: run_reg, longest: longest_new, clip: clip};

endmodule

`default_nettype wire

// ===== hw/rtl/blh_count.sv =====
// histogram update with clearing sweep, write forwarding and result register
`default_nettype none

module blh_count
    import blh_pkg::*;
#(
    parameter int HIST_BINS = 32,
    localparam int BIN_W = $clog2(HIST_BINS)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire burst_t           burst,
    input  wire logic [BIN_W-1:0] bin,
    output logic                  clearing,
    output logic                  result_valid,
    output logic      [LEN_W-1:0] burst_length,
    output logic      [CNT_W-1:0] bin_count,
    output logic      [LEN_W-1:0] longest_burst,
    output logic                  clipped
);

    logic             clr_active_reg, clr_active_next;
    logic [BIN_W-1:0] clr_addr_reg, clr_addr_next;

    logic             s2_valid_reg;
    logic [LEN_W-1:0] s2_len_reg;
    logic [LEN_W-1:0] s2_longest_reg;
    logic             s2_clip_reg;
    logic [BIN_W-1:0] s2_bin_reg;

    logic             fwd_hit_reg;
    logic [CNT_W-1:0] fwd_cnt_reg;

    logic             result_valid_reg;
    logic [LEN_W-1:0] burst_length_reg;
    logic [CNT_W-1:0] bin_count_reg;
    logic [LEN_W-1:0] longest_burst_reg;
    logic             clipped_reg;

    logic             ram_we;
    logic [BIN_W-1:0] ram_waddr;
    logic [CNT_W-1:0] ram_wdata;
    logic [CNT_W-1:0] ram_rdata;
    logic [CNT_W-1:0] cnt_old;
    logic [CNT_W-1:0] cnt_new;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + BIN_W'(1);
            if (clr_addr_reg == BIN_W'(HIST_BINS - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        cnt_old   = fwd_hit_reg ? fwd_cnt_reg : ram_rdata;
        cnt_new   = (cnt_old == CNT_MAX) ? cnt_old : (cnt_old + CNT_W'(1));
        ram_we    = clr_active_reg || (s2_valid_reg && advance);
        ram_waddr = clr_active_reg ? clr_addr_reg : s2_bin_reg;
        ram_wdata = clr_active_reg ? '0 : cnt_new;
    end

    blh_ram #(
        .WIDTH (CNT_W),
        .DEPTH (HIST_BINS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (advance),
        .raddr (bin),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg   <= 1'b1;
            clr_addr_reg     <= '0;
            s2_valid_reg     <= 1'b0;
            fwd_hit_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            if (advance)
            begin
                s2_valid_reg     <= burst.valid;
                fwd_hit_reg      <= burst.valid && s2_valid_reg && (s2_bin_reg == bin);
                result_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fwd_cnt_reg <= cnt_new;
            if (burst.valid)
            begin
                s2_len_reg     <= burst.length;
                s2_longest_reg <= burst.longest;
                s2_clip_reg    <= burst.clip;
                s2_bin_reg     <= bin;
            end
            if (s2_valid_reg)
            begin
                burst_length_reg  <= s2_len_reg;
                bin_count_reg     <= cnt_new;
                longest_burst_reg <= s2_longest_reg;
                clipped_reg       <= s2_clip_reg;
            end
        end
    end

    assign clearing      = clr_active_reg;
    assign result_valid  = result_valid_reg;
    assign burst_length  = burst_length_reg;
    assign bin_count     = bin_count_reg;
    assign longest_burst = longest_burst_reg;
    assign clipped       = clipped_reg;

    // no burst in flight while the histogram is being cleared
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !s2_valid_reg)
        else $error("burst in flight during clearing sweep");

    a_clip_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (clipped_reg == (burst_length_reg > LEN_W'(HIST_BINS - 1))))
        else $error("clip flag does not match burst length");

    a_longest: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (longest_burst_reg >= burst_length_reg))
        else $error("longest burst below current burst length");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (bin_count_reg != '0))
        else $error("bin count zero after increment");

endmodule

`default_nettype wire

// ===== hw/rtl/burst_length_histogram.sv =====
// top level of the burst length histogram
//
// samples arrive on the sample channel (sample_valid, sample_stall) with a
// timestamp and an event code; a transaction is taken when valid is high and
// stall is low. one sample can be taken every cycle while stall is low.
// a spike whose gap from the previous spike is not below gap_threshold closes
// the current burst and produces one result transaction on the result channel
// (result_valid, result_stall): burst length, updated bin count, longest burst
// so far and the clip flag. other samples produce nothing.
// from sample acceptance to result_valid a burst passes the input register,
// the registered read of the histogram ram and the result register.
// throughput is one sample per cycle while the pipeline is not frozen; a
// read-modify-write of the same bin on consecutive bursts is forwarded.
// when result_stall holds a waiting result, the pipeline freezes and
// sample_stall is raised until the result is taken.
// after reset a clearing sweep writes zero to all HIST_BINS bins, one per
// cycle, so sample_stall stays high until the sweep ends. configuration
// writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are always accepted and
// are meant to happen while the block is idle.
`default_nettype none

module burst_length_histogram
    import blh_pkg::*;
#(
    parameter int HIST_BINS = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              sample_valid,
    output logic                   sample_stall,
    input  wire logic [TIME_W-1:0] sample_time,
    input  wire logic [CODE_W-1:0] event_code,

    output logic                   result_valid,
    input  wire logic              result_stall,
    output logic      [LEN_W-1:0]  burst_length,
    output logic      [CNT_W-1:0]  bin_count,
    output logic      [LEN_W-1:0]  longest_burst,
    output logic                   clipped,

    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [DATA_W-1:0] cfg_data
);

    localparam int BIN_W = $clog2(HIST_BINS);

    logic [TIME_W-1:0] gap_threshold_reg, gap_threshold_next;
    logic [CODE_W-1:0] spike_marker_reg, spike_marker_next;

    logic             advance;
    logic             take;
    logic             clearing;
    burst_t           burst;
    logic [BIN_W-1:0] bin;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        gap_threshold_next = gap_threshold_reg;
        spike_marker_next  = spike_marker_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GAP_THRESHOLD: gap_threshold_next = cfg_data[TIME_W-1:0];
                REG_SPIKE_MARKER:  spike_marker_next  = cfg_data[CODE_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_threshold_reg <= GAP_THRESHOLD_RESET;
            spike_marker_reg  <= SPIKE_MARKER_RESET;
        end
        else
        begin
            gap_threshold_reg <= gap_threshold_next;
            spike_marker_reg  <= spike_marker_next;
        end
    end

    assign advance      = !(result_valid && result_stall);
    assign sample_stall = clearing || !advance;
    assign take         = sample_valid && !sample_stall;

    blh_front #(
        .HIST_BINS (HIST_BINS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .take          (take),
        .sample_time   (sample_time),
        .event_code    (event_code),
        .gap_threshold (gap_threshold_reg),
        .spike_marker  (spike_marker_reg),
        .burst         (burst),
        .bin           (bin)
    );

    blh_count #(
        .HIST_BINS (HIST_BINS)
    ) u_count (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .burst         (burst),
        .bin           (bin),
        .clearing      (clearing),
        .result_valid  (result_valid),
        .burst_length  (burst_length),
        .bin_count     (bin_count),
        .longest_burst (longest_burst),
        .clipped       (clipped)
    );

    // no sample taken during the sweep or while a result is held
    a_stall_cover: assert property (@(posedge clk) disable iff (!rst_n)
        (clearing || (result_valid && result_stall)) |-> sample_stall)
        else $error("sample channel open while pipeline cannot advance");

    a_no_result_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |=> !result_valid)
        else $error("result produced during clearing sweep");

endmodule

`default_nettype wire
